>>> design/box_iou_defines.svh
// assertion macros shared by the checker
`ifndef BOX_IOU_DEFINES_SVH
`define BOX_IOU_DEFINES_SVH

// clocked assertion, held off during reset
`define BIOU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// follow-up assertion, checked in the next cycle
`define BIOU_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> design/biou_pkg.sv
`timescale 1ns / 1ps
package biou_pkg;
    localparam int COORD_BITS_DEF     = 16;
    localparam int RATIO_FRAC_BITS_DEF = 16;
    localparam int RATIO_OUT_BITS     = 20;
    localparam int QUEUE_DEPTH        = 4;
endpackage

>>> design/biou_front.sv
`timescale 1ns / 1ps
module biou_front #(
    parameter int CB = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic signed [CB-1:0] a_left,
    input  logic signed [CB-1:0] a_top,
    input  logic        [CB-1:0] a_width,
    input  logic        [CB-1:0] a_height,
    input  logic signed [CB-1:0] b_left,
    input  logic signed [CB-1:0] b_top,
    input  logic        [CB-1:0] b_width,
    input  logic        [CB-1:0] b_height,
    input  logic                 full,
    output logic                 push,
    output logic [2*CB:0]        ov_out,
    output logic [2*CB+2:0]      uni_out
);
    import biou_pkg::*;

    logic adv;
    logic v1_reg, v2_reg, v3_reg;
    logic signed [CB+2:0] ew_reg, eh_reg, ew_next, eh_next;
    logic [CB-1:0] aw_reg, ah_reg, bw_reg, bh_reg;
    logic [2*CB:0] ov2_reg, ov2_next, ov3_reg;
    logic [2*CB-1:0] a1_reg, a2_reg;
    logic [2*CB+2:0] uni_reg;

    function automatic logic signed [CB+2:0] extent(
        input logic signed [CB-1:0] p1,
        input logic        [CB-1:0] s1,
        input logic signed [CB-1:0] p2,
        input logic        [CB-1:0] s2
    );
        logic signed [CB+1:0] e1, e2, hi, lo;
        e1 = $signed({{2{p1[CB-1]}}, p1}) + $signed({2'b00, s1});
        e2 = $signed({{2{p2[CB-1]}}, p2}) + $signed({2'b00, s2});
        hi = (e1 < e2) ? e1 : e2;
        lo = (p1 > p2) ? $signed({{2{p1[CB-1]}}, p1}) : $signed({{2{p2[CB-1]}}, p2});
        return $signed({hi[CB+1], hi}) - $signed({lo[CB+1], lo})
            + $signed((CB+3)'(1));
    endfunction

    assign adv       = !full;
    assign req_stall = full;
    assign push      = adv && v3_reg;
    assign ov_out    = ov3_reg;
    assign uni_out   = uni_reg;

    assign ew_next = extent(a_left, a_width, b_left, b_width);
    assign eh_next = extent(a_top, a_height, b_top, b_height);

    always_comb
    begin
        if (!ew_reg[CB+2] && (ew_reg != '0) && !eh_reg[CB+2] && (eh_reg != '0))
        begin
            ov2_next = (2*CB+1)'(ew_reg[CB:0] * eh_reg[CB:0]);
        end
        else
        begin
            ov2_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ew_reg  <= ew_next;
            eh_reg  <= eh_next;
            aw_reg  <= a_width;
            ah_reg  <= a_height;
            bw_reg  <= b_width;
            bh_reg  <= b_height;
            ov2_reg <= ov2_next;
            a1_reg  <= aw_reg * ah_reg;
            a2_reg  <= bw_reg * bh_reg;
            ov3_reg <= ov2_reg;
            uni_reg <= {3'b000, a1_reg} + {3'b000, a2_reg} - {2'b00, ov2_reg};
        end
    end
endmodule

>>> design/biou_queue.sv
`timescale 1ns / 1ps
module biou_queue #(
    parameter int W = 68
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] dout
);
    import biou_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0] mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;

    assign full      = (cnt_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign dout      = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= din;
        end
    end
endmodule

>>> design/biou_div.sv
`timescale 1ns / 1ps
module biou_div #(
    parameter int CB = 16,
    parameter int F  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  logic [2*CB:0]                     head_ov,
    input  logic [2*CB+2:0]                   head_uni,
    output logic                              pop,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [2*CB:0]                     overlap_area,
    output logic [biou_pkg::RATIO_OUT_BITS-1:0] iou_ratio,
    output logic                              ratio_saturated,
    output logic                              union_nonpositive
);
    import biou_pkg::*;

    localparam int RB    = RATIO_OUT_BITS;
    localparam int OV_W  = 2*CB + 1;
    localparam int REM_W = 2*CB + 3;
    localparam int NW    = OV_W + F;
    localparam int HW    = NW - RB;
    localparam int CW    = (HW > REM_W) ? HW : REM_W;

    logic adv;
    logic            v_reg   [RB+1];
    logic [REM_W-1:0] rem_reg [RB+1];
    logic [RB-1:0]   q_reg   [RB+1];
    logic [RB-1:0]   low_reg [RB+1];
    logic [REM_W-1:0] den_reg [RB+1];
    logic [OV_W-1:0] ov_reg  [RB+1];
    logic            sat_reg [RB+1];
    logic            np_reg  [RB+1];

    logic [NW-1:0]    num;
    logic [CW-1:0]    hi_ext, den_ext;
    logic             np0;
    logic [REM_W-1:0] t_val [RB+1];
    logic             ge    [RB+1];

    assign adv = !v_reg[RB] || !res_stall;
    assign pop = adv && head_valid;

    assign num     = {head_ov, F'(0)};
    assign hi_ext  = CW'(num[NW-1:RB]);
    assign den_ext = CW'(head_uni);
    assign np0     = head_uni[REM_W-1] || (head_uni == '0);

    always_comb
    begin
        t_val[0] = '0;
        ge[0]    = 1'b0;
        for (int i = 1; i <= RB; i++)
        begin
            t_val[i] = {rem_reg[i-1][REM_W-2:0], low_reg[i-1][RB-i]};
            ge[i]    = (t_val[i] >= den_reg[i-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= RB; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= head_valid;
            for (int i = 1; i <= RB; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= hi_ext[REM_W-1:0];
            q_reg[0]   <= '0;
            low_reg[0] <= num[RB-1:0];
            den_reg[0] <= head_uni;
            ov_reg[0]  <= head_ov;
            np_reg[0]  <= np0;
            sat_reg[0] <= !np0 && (hi_ext >= den_ext);
            for (int i = 1; i <= RB; i++)
            begin
                rem_reg[i] <= ge[i] ? t_val[i] - den_reg[i-1] : t_val[i];
                q_reg[i]   <= {q_reg[i-1][RB-2:0], ge[i]};
                low_reg[i] <= low_reg[i-1];
                den_reg[i] <= den_reg[i-1];
                ov_reg[i]  <= ov_reg[i-1];
                np_reg[i]  <= np_reg[i-1];
                sat_reg[i] <= sat_reg[i-1];
            end
        end
    end

    assign res_valid         = v_reg[RB];
    assign overlap_area      = ov_reg[RB];
    assign ratio_saturated   = sat_reg[RB];
    assign union_nonpositive = np_reg[RB];
    assign iou_ratio         = np_reg[RB] ? '0 : (sat_reg[RB] ? '1 : q_reg[RB]);
endmodule

>>> design/box_iou.sv
`timescale 1ns / 1ps
// path: each box pair goes through the three-stage front, a four-entry queue
// and the one-bit-per-stage divider pipeline of 21 stages; throughput is one box
// pair per cycle while the queue is not full and the result is not stalled
// reset: rst_n clears all valid flags and queue pointers, so no result is
// shown until a new request is taken
module box_iou #(
    parameter int COORD_BITS      = biou_pkg::COORD_BITS_DEF,
    parameter int RATIO_FRAC_BITS = biou_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic signed [COORD_BITS-1:0]        a_left,
    input  logic signed [COORD_BITS-1:0]        a_top,
    input  logic        [COORD_BITS-1:0]        a_width,
    input  logic        [COORD_BITS-1:0]        a_height,
    input  logic signed [COORD_BITS-1:0]        b_left,
    input  logic signed [COORD_BITS-1:0]        b_top,
    input  logic        [COORD_BITS-1:0]        b_width,
    input  logic        [COORD_BITS-1:0]        b_height,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic [2*COORD_BITS:0]               overlap_area,
    output logic [biou_pkg::RATIO_OUT_BITS-1:0] iou_ratio,
    output logic                                ratio_saturated,
    output logic                                union_nonpositive
);
    import biou_pkg::*;

    localparam int OV_W  = 2*COORD_BITS + 1;
    localparam int UNI_W = 2*COORD_BITS + 3;

    logic full, push, pop, not_empty;
    logic [OV_W-1:0] f_ov, h_ov;
    logic [UNI_W-1:0] f_uni, h_uni;

    biou_front #(.CB(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .a_left(a_left), .a_top(a_top), .a_width(a_width), .a_height(a_height),
        .b_left(b_left), .b_top(b_top), .b_width(b_width), .b_height(b_height),
        .full(full), .push(push), .ov_out(f_ov), .uni_out(f_uni)
    );

    biou_queue #(.W(OV_W + UNI_W)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .din({f_ov, f_uni}), .full(full),
        .pop(pop), .not_empty(not_empty), .dout({h_ov, h_uni})
    );

    biou_div #(.CB(COORD_BITS), .F(RATIO_FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n),
        .head_valid(not_empty), .head_ov(h_ov), .head_uni(h_uni),
        .pop(pop), .res_valid(res_valid), .res_stall(res_stall),
        .overlap_area(overlap_area), .iou_ratio(iou_ratio),
        .ratio_saturated(ratio_saturated), .union_nonpositive(union_nonpositive)
    );
endmodule

>>> design/box_iou_chk.sv
`timescale 1ns / 1ps
`include "box_iou_defines.svh"
module box_iou_chk #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                res_valid,
    input logic                                res_stall,
    input logic [2*COORD_BITS:0]               overlap_area,
    input logic [biou_pkg::RATIO_OUT_BITS-1:0] iou_ratio,
    input logic                                ratio_saturated,
    input logic                                union_nonpositive
);
    import biou_pkg::*;

    `BIOU_ASSERT_NEXT(a_hold, res_valid && res_stall, res_valid, "result dropped while stalled")
    `BIOU_ASSERT(a_nonpos, res_valid && union_nonpositive |-> iou_ratio == '0 && !ratio_saturated, "bad ratio for empty union")
    `BIOU_ASSERT(a_sat, res_valid && ratio_saturated |-> iou_ratio == '1 && !union_nonpositive, "saturation without full scale")
    `BIOU_ASSERT(a_zero, res_valid && overlap_area == '0 |-> iou_ratio == '0 && !ratio_saturated, "ratio without overlap")
endmodule

bind box_iou box_iou_chk #(.COORD_BITS(COORD_BITS)) u_chk (
    .clk(clk), .rst_n(rst_n), .res_valid(res_valid), .res_stall(res_stall),
    .overlap_area(overlap_area), .iou_ratio(iou_ratio),
    .ratio_saturated(ratio_saturated), .union_nonpositive(union_nonpositive)
);
